@@ rtl/imhq_pkg.sv @@
//------------------------------------------------------------------------------
// imhq_pkg
// shared types and constants of the indexed min-heap queue
//------------------------------------------------------------------------------
package imhq_pkg;

   localparam int CellW = 16;
   localparam int KeyW  = 48;

   typedef enum logic [2:0] {
      ACT_INSERT = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_REKEY  = 3'd2,
      ACT_POP    = 3'd3,
      ACT_CLEAR  = 3'd4,
      ACT_QUERY  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_DUP    = 2'd2,
      ST_ABSENT = 2'd3
   } status_type;

   // strictly-less compare of two heap keys, primary part in the upper half
   function automatic logic key_less(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
      return a < b;
   endfunction

endpackage

@@ rtl/imhq_core.sv @@
//------------------------------------------------------------------------------
// imhq_core
// heap slot memories, position map and the sequencer that sifts entries
//------------------------------------------------------------------------------
module imhq_core #(
   parameter int MAP_CELLS = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  imhq_pkg::action_type         action,
   input  logic [imhq_pkg::CellW-1:0]   cell_idx,
   input  logic [imhq_pkg::KeyW-1:0]    key,
   output logic                         busy,
   output logic                         done,
   output logic [101:0]                 result
);
   import imhq_pkg::*;

   localparam int PW = $clog2(MAP_CELLS);   // slot index width
   localparam int CW = $clog2(MAP_CELLS + 1);

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_CLR    = 14'b00000000000010,
      S_LOOK   = 14'b00000000000100,
      S_DECIDE = 14'b00000000001000,
      S_LAST   = 14'b00000000010000,
      S_MOVE   = 14'b00000000100000,
      S_SWRD   = 14'b00000001000000,
      S_SWCMP  = 14'b00000010000000,
      S_SKRD   = 14'b00000100000000,
      S_SKCMP  = 14'b00001000000000,
      S_SWAP   = 14'b00010000000000,
      S_WIPE   = 14'b00100000000000,
      S_TOP    = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   // memories
   logic [CellW-1:0] slot_cell_mem [MAP_CELLS];
   logic [KeyW-1:0]  slot_key_mem  [MAP_CELLS];
   logic [CW-1:0]    pos_mem       [MAP_CELLS];  // slot + 1, zero is absent

   state_type state_ff, state_in;
   logic [PW:0]      clr_ff, clr_in;
   logic [CW-1:0]    count_ff, count_in;
   action_type       act_ff, act_in;
   logic [CellW-1:0] cell_ff, cell_in;
   logic [KeyW-1:0]  key_ff, key_in;
   logic             inmap_ff, inmap_in;
   logic [CW-1:0]    pos_rd_ff;
   logic [PW-1:0]    cur_ff, cur_in;         // slot being sifted
   logic [CellW-1:0] cur_cell_ff, cur_cell_in;
   logic [KeyW-1:0]  cur_key_ff, cur_key_in;
   logic [PW-1:0]    oth_ff, oth_in;         // parent of the current slot
   logic [CellW-1:0] ca_ff, cb_ff;
   logic [KeyW-1:0]  ka_ff, kb_ff;
   logic             up_ff, up_in;           // sink pending or in progress; wipe read valid
   logic             was_ff, was_in;
   status_type       st_ff, st_in;
   logic             pv_ff, pv_in;
   logic [CellW-1:0] pc_ff, pc_in;
   logic [KeyW-1:0]  pk_ff, pk_in;
   logic [CellW-1:0] top_cell;

   // memory port controls
   logic             sc_we;  logic [PW-1:0] sc_wa; logic [CellW-1:0] sc_wd;
   logic             sk_we;  logic [KeyW-1:0] sk_wd;
   logic [PW-1:0]    ra, rb;
   logic             pm_we;  logic [CellW-1:0] pm_wa; logic [CW-1:0] pm_wd;
   logic             pm2_we; logic [CellW-1:0] pm2_wa; logic [CW-1:0] pm2_wd;
   logic [CellW-1:0] pm_ra;
   logic [PW:0]      lc, rc;

   // slot memories: one write, two registered reads
   always_ff @(posedge clock) begin
      if (sc_we) slot_cell_mem[sc_wa] <= sc_wd;
      if (sk_we) slot_key_mem[sc_wa]  <= sk_wd;
      ca_ff <= slot_cell_mem[ra];
      ka_ff <= slot_key_mem[ra];
      cb_ff <= slot_cell_mem[rb];
      kb_ff <= slot_key_mem[rb];
   end

   // position map: two writes for a swap, one registered read
   always_ff @(posedge clock) begin
      if (pm_we)  pos_mem[PW'(pm_wa)]  <= pm_wd;
      if (pm2_we) pos_mem[PW'(pm2_wa)] <= pm2_wd;
      pos_rd_ff <= pos_mem[PW'(pm_ra)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
      act_ff <= act_in;   cell_ff <= cell_in;   key_ff <= key_in;
      inmap_ff <= inmap_in; cur_ff <= cur_in;   cur_cell_ff <= cur_cell_in;
      cur_key_ff <= cur_key_in; oth_ff <= oth_in; up_ff <= up_in;
      was_ff <= was_in;   st_ff <= st_in;       pv_ff <= pv_in;
      pc_ff <= pc_in;     pk_ff <= pk_in;
   end

   assign lc = {cur_ff, 1'b1};
   assign rc = {cur_ff, 1'b1} + 1'b1;

   always_comb begin
      logic [PW-1:0] pick;
      logic [CellW-1:0] pcell;
      logic [KeyW-1:0] pkey;
      state_in = state_ff; clr_in = clr_ff; count_in = count_ff;
      act_in = act_ff; cell_in = cell_ff; key_in = key_ff; inmap_in = inmap_ff;
      cur_in = cur_ff; cur_cell_in = cur_cell_ff; cur_key_in = cur_key_ff;
      oth_in = oth_ff; up_in = up_ff; was_in = was_ff; st_in = st_ff;
      pv_in = pv_ff; pc_in = pc_ff; pk_in = pk_ff;
      sc_we = 1'b0; sk_we = 1'b0; sc_wa = cur_ff; sc_wd = cur_cell_ff; sk_wd = cur_key_ff;
      ra = cur_ff; rb = oth_ff;
      pm_we = 1'b0; pm_wa = cur_cell_ff; pm_wd = '0;
      pm2_we = 1'b0; pm2_wa = cur_cell_ff; pm2_wd = '0;
      pm_ra = cell_ff;
      done = 1'b0;
      pick = lc[PW-1:0]; pcell = cb_ff; pkey = kb_ff;
      case (state_ff)
         // clearing pass over the position map
         S_CLR: begin
            pm_we = 1'b1; pm_wa = CellW'(clr_ff[PW-1:0]); pm_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (PW+1)'(MAP_CELLS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            pm_ra = cell_idx;
            if (start) begin
               act_in = action; cell_in = cell_idx; key_in = key;
               inmap_in = 32'(cell_idx) < MAP_CELLS;
               pv_in = 1'b0; pc_in = '0; pk_in = '0; st_in = ST_OK;
               state_in = S_LOOK;
            end
         end
         // position map read of the named cell arrives; read top and last slot
         S_LOOK: begin
            was_in = inmap_ff && pos_rd_ff != '0;
            ra = '0; rb = PW'(count_ff - 1'b1);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_TOP;
            case (act_ff)
               ACT_INSERT: begin
                  if (!inmap_ff) st_in = ST_ABSENT;
                  else if (was_ff) st_in = ST_DUP;
                  else if (32'(count_ff) >= MAP_CELLS) st_in = ST_FULL;
                  else begin
                     cur_in = PW'(count_ff); cur_cell_in = cell_ff; cur_key_in = key_ff;
                     count_in = count_ff + 1'b1; up_in = 1'b0;
                     state_in = S_MOVE;
                  end
               end
               ACT_DELETE, ACT_POP: begin
                  if (act_ff == ACT_POP) begin
                     was_in = 1'b0;
                     if (count_ff != '0) begin
                        pv_in = 1'b1; pc_in = ca_ff; pk_in = ka_ff;
                        cur_in = '0; pm_ra = ca_ff; state_in = S_LAST;
                     end
                  end else if (!was_ff) st_in = ST_ABSENT;
                  else begin
                     cur_in = PW'(pos_rd_ff - 1'b1); pm_ra = cell_ff; state_in = S_LAST;
                  end
                  cur_cell_in = cb_ff; cur_key_in = kb_ff;
               end
               ACT_REKEY: begin
                  if (!was_ff) st_in = ST_ABSENT;
                  else begin
                     cur_in = PW'(pos_rd_ff - 1'b1); cur_cell_in = cell_ff;
                     cur_key_in = key_ff; up_in = 1'b1; state_in = S_MOVE;
                  end
               end
               ACT_CLEAR: begin
                  was_in = 1'b0; cur_in = '0; up_in = 1'b0;
                  if (count_ff != '0) state_in = S_WIPE;
               end
               default: ;
            endcase
         end
         // drop the removed cell, move the last entry into the hole
         S_LAST: begin
            pm_we = 1'b1; pm_wa = (act_ff == ACT_POP) ? pc_ff : cell_ff; pm_wd = '0;
            count_in = count_ff - 1'b1;
            if ((CW'(cur_ff) + 1'b1) == count_ff) state_in = S_TOP;
            else begin up_in = 1'b1; state_in = S_MOVE; end
         end
         // place current entry at its slot, then sift up, or sink first for a rekey
         S_MOVE: begin
            sc_we = 1'b1; sk_we = 1'b1;
            pm2_we = 1'b1; pm2_wa = cur_cell_ff; pm2_wd = CW'(cur_ff) + 1'b1;
            state_in = (act_ff == ACT_REKEY) ? S_SKRD : S_SWRD;
         end
         S_SWRD: begin
            oth_in = PW'((cur_ff - 1'b1) >> 1); rb = PW'((cur_ff - 1'b1) >> 1);
            if (cur_ff == '0) state_in = up_ff && act_ff != ACT_INSERT
                                         && act_ff != ACT_REKEY ? S_SKRD : S_TOP;
            else state_in = S_SWCMP;
         end
         S_SWCMP: begin
            if (key_less(cur_key_ff, kb_ff)) begin
               sc_wa = cur_ff; sc_wd = cb_ff; sk_wd = kb_ff; sc_we = 1'b1; sk_we = 1'b1;
               pm_we = 1'b1; pm_wa = cb_ff; pm_wd = CW'(cur_ff) + 1'b1;
               cur_in = oth_ff; state_in = S_SWAP;
               up_in = 1'b0;
            end else
               state_in = (up_ff && act_ff != ACT_INSERT && act_ff != ACT_REKEY)
                          ? S_SKRD : S_TOP;
         end
         // the current entry rides along in registers, write it at its new slot
         S_SWAP: begin
            sc_we = 1'b1; sk_we = 1'b1;
            pm2_we = 1'b1; pm2_wa = cur_cell_ff; pm2_wd = CW'(cur_ff) + 1'b1;
            state_in = (up_ff) ? S_SKRD : S_SWRD;
         end
         S_SKRD: begin
            ra = lc[PW-1:0]; rb = rc[PW-1:0];
            if (32'(lc) >= 32'(count_ff))
               state_in = (act_ff == ACT_REKEY) ? S_SWRD : S_TOP;
            else state_in = S_SKCMP;
            if (act_ff == ACT_REKEY) up_in = 1'b0;
         end
         S_SKCMP: begin
            pick = lc[PW-1:0]; pcell = ca_ff; pkey = ka_ff;
            if (32'(rc) < 32'(count_ff) && key_less(kb_ff, ka_ff)) begin
               pick = rc[PW-1:0]; pcell = cb_ff; pkey = kb_ff;
            end
            if (key_less(pkey, cur_key_ff)) begin
               sc_wa = cur_ff; sc_wd = pcell; sk_wd = pkey; sc_we = 1'b1; sk_we = 1'b1;
               pm_we = 1'b1; pm_wa = pcell; pm_wd = CW'(cur_ff) + 1'b1;
               cur_in = pick; up_in = 1'b1; state_in = S_SWAP;
            end else
               state_in = (act_ff == ACT_REKEY) ? S_SWRD : S_TOP;
         end
         // clear position entries of every queued cell
         S_WIPE: begin
            ra = cur_ff;
            state_in = S_WIPE;
            if (up_ff) begin
               pm_we = 1'b1; pm_wa = ca_ff; pm_wd = '0;
            end
            up_in = 1'b1; cur_in = cur_ff + 1'b1;
            if (up_ff && ((cur_ff - 1'b1) == PW'(count_ff - 1'b1))) begin
               count_in = '0; state_in = S_TOP;
            end
         end
         // read the top slot once every write has landed
         S_TOP: begin
            ra = '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
            done = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;
   assign top_cell = (count_ff != '0) ? ca_ff : '0;
   assign result = {st_ff, 17'(count_ff), top_cell, (count_ff != '0), was_ff,
                    pk_ff[23:0], pk_ff[47:24], pc_ff, pv_ff};
endmodule

@@ rtl/indexed_min_heap_queue.sv @@
//------------------------------------------------------------------------------
// indexed_min_heap_queue
// indexed binary min-heap of map cells with position map and registered output
//------------------------------------------------------------------------------
// each heap level an entry moves takes a read, a compare and a write on the
// single slot memory port pair; a clear walks every queued slot before the
// response is given.
// one request in flight at a time; the next is taken once the response has left.
// after reset a clearing pass empties the position map while req_tready is low.
module indexed_min_heap_queue #(
   parameter int MAP_CELLS = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[2:0], cell_index[18:3], key_primary[42:19], key_secondary[66:43]
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // popped_valid, popped_cell, popped_key_primary, popped_key_secondary,
   // was_present, top_valid, top_cell, entry_count, status
   output logic [103:0] rsp_tdata
);
   import imhq_pkg::*;

   logic         busy, done;
   logic [101:0] result;
   logic         full_ff, full_in;
   logic [101:0] out_ff;

   imhq_core #(.MAP_CELLS(MAP_CELLS)) u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (req_tvalid && req_tready),
      .action   (action_type'(req_tdata[2:0])),
      .cell_idx (req_tdata[18:3]),
      .key      ({req_tdata[42:19], req_tdata[66:43]}),
      .busy     (busy),
      .done     (done),
      .result   (result)
   );

   // output register
   always_comb begin
      full_in = full_ff;
      if (rsp_tvalid && rsp_tready) full_in = 1'b0;
      if (done) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      if (done) out_ff <= result;
   end

   assign req_tready = !busy && !full_ff;
   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = {2'd0, out_ff};
endmodule

@@ test/imhq_checker.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// imhq_checker
// watches the request and response streams of the indexed min-heap queue,
// keeps its own heap and position map, and compares every response field
//------------------------------------------------------------------------------
module imhq_checker
   import imhq_pkg::*;
#(
   parameter int CELLS = 65536,
   parameter int RSP_W = 104
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [71:0]      req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               answers_waiting,
   output int               answers_seen
);

   typedef struct {
      logic        pop_valid;
      logic [15:0] pop_cell;
      logic [23:0] pop_kp;
      logic [23:0] pop_ks;
      logic        was_queued;
      logic        top_valid;
      logic [15:0] top_cell;
      logic [16:0] count;
      logic [1:0]  status;
   } heap_answer_type;

   // mirror of the heap: slot contents and cell to slot+1 map (0 = absent)
   logic [15:0] mirror_cell [CELLS];
   logic [47:0] mirror_key  [CELLS];
   int          mirror_pos  [CELLS];
   int          mirror_count;

   heap_answer_type answer_fifo[$];

   initial begin
      for (int i = 0; i < CELLS; i++) mirror_pos[i] = 0;
      mirror_count = 0;
   end

   function automatic void swap_slots(int a, int b);
      logic [15:0] c;
      logic [47:0] k;
      c = mirror_cell[a];
      k = mirror_key[a];
      mirror_cell[a] = mirror_cell[b];
      mirror_key[a]  = mirror_key[b];
      mirror_cell[b] = c;
      mirror_key[b]  = k;
      mirror_pos[mirror_cell[a]] = a + 1;
      mirror_pos[mirror_cell[b]] = b + 1;
   endfunction

   function automatic int float_up(int pos);
      int parent;
      while (pos > 0) begin
         parent = (pos - 1) / 2;
         if (mirror_key[pos] < mirror_key[parent]) begin
            swap_slots(pos, parent);
            pos = parent;
         end else break;
      end
      return pos;
   endfunction

   function automatic int sift_down(int pos);
      int lchild;
      int pick;
      forever begin
         lchild = 2 * pos + 1;
         if (lchild >= mirror_count) break;
         pick = lchild;
         if (lchild + 1 < mirror_count && mirror_key[lchild + 1] < mirror_key[lchild])
            pick = lchild + 1;
         if (mirror_key[pick] < mirror_key[pos]) begin
            swap_slots(pos, pick);
            pos = pick;
         end else break;
      end
      return pos;
   endfunction

   function automatic void drop_slot(int pos);
      int last;
      last = mirror_count - 1;
      mirror_pos[mirror_cell[pos]] = 0;
      mirror_count = last;
      if (pos != last) begin
         mirror_cell[pos] = mirror_cell[last];
         mirror_key[pos]  = mirror_key[last];
         mirror_pos[mirror_cell[pos]] = pos + 1;
         pos = float_up(pos);
         void'(sift_down(pos));
      end
   endfunction

   // apply one request to the mirror and work out its response
   function automatic heap_answer_type apply_request(logic [71:0] d);
      heap_answer_type a;
      logic [2:0]   act;
      int           cidx;
      logic [47:0]  key;
      logic         queued;
      int           pos;
      act    = d[2:0];
      cidx   = int'(d[18:3]);
      key    = {d[42:19], d[66:43]};
      queued = (cidx < CELLS) && (mirror_pos[cidx] != 0);
      a = '{default: '0};
      a.status     = ST_OK;
      a.was_queued = queued;
      case (act)
         ACT_INSERT: begin
            if (cidx >= CELLS) a.status = ST_ABSENT;
            else if (queued) a.status = ST_DUP;
            else if (mirror_count >= CELLS) a.status = ST_FULL;
            else begin
               mirror_cell[mirror_count] = 16'(cidx);
               mirror_key[mirror_count]  = key;
               mirror_pos[cidx] = mirror_count + 1;
               mirror_count++;
               void'(float_up(mirror_count - 1));
            end
         end
         ACT_DELETE: begin
            if (!queued) a.status = ST_ABSENT;
            else drop_slot(mirror_pos[cidx] - 1);
         end
         ACT_REKEY: begin
            if (!queued) a.status = ST_ABSENT;
            else begin
               pos = mirror_pos[cidx] - 1;
               mirror_key[pos] = key;
               pos = sift_down(pos);
               void'(float_up(pos));
            end
         end
         ACT_POP: begin
            a.was_queued = 1'b0;
            if (mirror_count > 0) begin
               a.pop_valid = 1'b1;
               a.pop_cell  = mirror_cell[0];
               a.pop_kp    = mirror_key[0][47:24];
               a.pop_ks    = mirror_key[0][23:0];
               drop_slot(0);
            end
         end
         ACT_CLEAR: begin
            a.was_queued = 1'b0;
            for (int i = 0; i < mirror_count; i++) mirror_pos[mirror_cell[i]] = 0;
            mirror_count = 0;
         end
         default: ;
      endcase
      a.top_valid = mirror_count > 0;
      a.top_cell  = mirror_count > 0 ? mirror_cell[0] : 16'd0;
      a.count     = 17'(mirror_count);
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch in response %0d: %s got %0h expected %0h",
               $time, answers_seen, what, got, want);
      fail_count++;
   endtask

   // compare one field if it lies inside the response bus
   task automatic check_field(logic [127:0] r, string what, int lo, int w, logic [31:0] want);
      logic [31:0] got;
      if (lo + w <= RSP_W) begin
         got = 32'((r >> lo) & ((128'd1 << w) - 1));
         if (got !== want) report_mismatch(what, got, want);
      end
   endtask

   initial begin
      fail_count = 0;
      answers_seen = 0;
      answers_waiting = 0;
   end

   always @(posedge clock) begin
      heap_answer_type want;
      logic [127:0] r;
      if (!reset) begin
         if (req_tvalid && req_tready)
            answer_fifo.insert(answer_fifo.size(), apply_request(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            r = '0;
            r[RSP_W-1:0] = rsp_tdata;
            if (answer_fifo.size() == 0) begin
               $display("%0t response with no request waiting", $time);
               fail_count++;
            end else begin
               want = answer_fifo.pop_front();
               check_field(r, "popped_valid", 0, 1, 32'(want.pop_valid));
               check_field(r, "popped_cell", 1, 16, 32'(want.pop_cell));
               check_field(r, "popped_key_primary", 17, 24, 32'(want.pop_kp));
               check_field(r, "popped_key_secondary", 41, 24, 32'(want.pop_ks));
               check_field(r, "was_present", 65, 1, 32'(want.was_queued));
               check_field(r, "top_valid", 66, 1, 32'(want.top_valid));
               check_field(r, "top_cell", 67, 16, 32'(want.top_cell));
               check_field(r, "entry_count", 83, 17, 32'(want.count));
               check_field(r, "status", 100, 2, 32'(want.status));
            end
            answers_seen++;
         end
         answers_waiting = answer_fifo.size();
      end
   end

endmodule

@@ test/tb_indexed_min_heap_queue.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_indexed_min_heap_queue
// directed and random heap requests with random idling on both streams;
// the checker beside the block predicts and compares every response
//------------------------------------------------------------------------------
module tb_indexed_min_heap_queue;
   import imhq_pkg::*;

   localparam int RANDOM_REQUESTS = 1830;
   localparam int QUIET_TAIL      = 250;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [71:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   int           fail_count;
   int           answers_waiting;
   int           answers_seen;
   int           requests_sent;
   logic         quiet;

   indexed_min_heap_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   imhq_checker #(.CELLS(65536), .RSP_W(104)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .answers_waiting (answers_waiting),
      .answers_seen    (answers_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit: clearing pass plus slow worst case, several times over
   initial begin
      #20ms;
      $display("timeout with %0d responses outstanding", answers_waiting);
      $display("[indexed_min_heap_queue] ERROR");
      $finish;
   end

   // response back-pressure in random bursts, none once quiet
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   // one request: hold it until the block takes it
   task automatic send_request(action_type act, logic [15:0] cidx, logic [23:0] kp,
                               logic [23:0] ks);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tdata  = {5'd0, ks, kp, cidx, act};
      req_tvalid = 1'b1;
      while (!req_tready) @(negedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      requests_sent++;
   endtask

   function automatic logic [23:0] pick_key();
      if ($urandom_range(0, 1)) return 24'($urandom_range(0, 7));
      return 24'($urandom);
   endfunction

   function automatic logic [15:0] pick_cell();
      case ($urandom_range(0, 9))
         0:       return 16'($urandom);
         1:       return 16'hFFFF - 16'($urandom_range(0, 3));
         default: return 16'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      int          roll;
      action_type  act;
      logic [2:0]  raw;
      quiet         = 1'b0;
      requests_sent = 0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // directed: empty heap cases, extremes, ties, last-slot delete, unused codes
      send_request(ACT_QUERY, 16'd0, 24'd0, 24'd0);
      send_request(ACT_POP, 16'd0, 24'd0, 24'd0);
      send_request(ACT_DELETE, 16'd5, 24'd0, 24'd0);
      send_request(ACT_REKEY, 16'd5, 24'd1, 24'd1);
      send_request(ACT_INSERT, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
      send_request(ACT_INSERT, 16'hFFFF, 24'd0, 24'd0);
      send_request(ACT_INSERT, 16'hFFFF, 24'd3, 24'd3);
      send_request(ACT_INSERT, 16'd1, 24'd7, 24'd7);
      send_request(ACT_INSERT, 16'd2, 24'd7, 24'd7);
      send_request(ACT_INSERT, 16'd3, 24'd7, 24'd6);
      send_request(ACT_INSERT, 16'd4, 24'd6, 24'hFFFFFF);
      send_request(ACT_REKEY, 16'd1, 24'd0, 24'd0);
      send_request(ACT_REKEY, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFE);
      send_request(ACT_QUERY, 16'hFFFF, 24'd0, 24'd0);
      send_request(action_type'(3'd6), 16'd2, 24'd0, 24'd0);
      send_request(action_type'(3'd7), 16'd9, 24'd0, 24'd0);
      send_request(ACT_DELETE, 16'd0, 24'd0, 24'd0);
      send_request(ACT_DELETE, 16'd2, 24'd0, 24'd0);
      send_request(ACT_POP, 16'd0, 24'd0, 24'd0);
      send_request(ACT_POP, 16'd0, 24'd0, 24'd0);
      send_request(ACT_CLEAR, 16'd0, 24'd0, 24'd0);
      send_request(ACT_QUERY, 16'd3, 24'd0, 24'd0);
      send_request(ACT_POP, 16'd0, 24'd0, 24'd0);

      // random mix weighted toward inserts so the heap grows deep
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
         roll = $urandom_range(0, 99);
         if (roll < 40) act = ACT_INSERT;
         else if (roll < 55) act = ACT_POP;
         else if (roll < 67) act = ACT_DELETE;
         else if (roll < 82) act = ACT_REKEY;
         else if (roll < 93) act = ACT_QUERY;
         else if (roll < 95) act = ACT_CLEAR;
         else begin
            raw = 3'($urandom_range(6, 7));
            act = action_type'(raw);
         end
         send_request(act, pick_cell(), pick_key(), pick_key());
      end

      while (answers_waiting != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      $display("sent %0d heap requests (insert, delete, rekey, pop, clear, query)", requests_sent);
      $display("checked %0d responses against the mirrored heap", answers_seen);
      if (fail_count == 0) $display("[indexed_min_heap_queue] OK");
      else $display("[indexed_min_heap_queue] ERROR");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/imhq_pkg.sv
rtl/imhq_core.sv
rtl/indexed_min_heap_queue.sv
test/imhq_checker.sv
test/tb_indexed_min_heap_queue.sv
